### sv/hmd_pkg.sv
// Types and constants shared by the host message deframer.
package hmd_pkg;

    // Parser phases, one per header field plus payload and trailing-byte skip.
    typedef enum logic [2:0] {
        PH_SEQ     = 3'd0,
        PH_TAG     = 3'd1,
        PH_CLIENT  = 3'd2,
        PH_LEN     = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_IGNORE  = 3'd5
    } phase_t;

    // Kind of a result word, carried on m_tuser.
    typedef enum logic [1:0] {
        EV_BYTE   = 2'd0,
        EV_ACCEPT = 2'd1,
        EV_REJECT = 2'd2
    } event_t;

    localparam logic [1:0] MSG_CONNECT    = 2'd0;
    localparam logic [1:0] MSG_DISCONNECT = 2'd1;
    localparam logic [1:0] MSG_STATE      = 2'd2;

    localparam logic [15:0] TAG_CONNECT    = 16'd0;
    localparam logic [15:0] TAG_DISCONNECT = 16'd1;
    localparam logic [15:0] TAG_STATE      = 16'd2;

    localparam logic RSN_TRUNCATED   = 1'b0;
    localparam logic RSN_UNKNOWN_TAG = 1'b1;

    // Result queue geometry.
    localparam int QDepth = 4;
    localparam int QAw    = 2;
    localparam int QCw    = 3;

    typedef struct packed {
        event_t      event_res;
        logic [1:0]  msg_type;
        logic [63:0] seq_number;
        logic [15:0] client_id;
        logic [31:0] payload_length;
        logic [7:0]  payload_byte;
        logic        payload_last;
        logic        reject_reason;
    } result_t;

endpackage

### sv/host_message_deframer_core.sv
// Host message deframer: byte-serial header parser with payload forwarding.
//
// The block takes the bytes of one received buffer, one byte per input word, with
// s_tlast on the last byte of the buffer. Each buffer carries at most one message:
// a little-endian 64-bit sequence number, a 16-bit tag, then a body chosen by the
// tag (tag 0 a 16-bit client id, tag 1 nothing, tag 2 a 32-bit length followed by
// that many payload bytes). Payload bytes are forwarded as soon as they arrive; the
// verdict word (accepted, or rejected as truncated or as an unknown tag) follows
// once it is known, and a consumer must drop forwarded payload of a rejected
// message. Bytes after a finished message are ignored, and the end of a buffer
// always returns the parser to the start of a header. Each input word is parsed in
// the cycle it is accepted, so one byte enters per clock while s_tready is high.
// A byte yields zero, one or two result words; they go into a four-word result
// queue that the output side drains at one word per clock while m_tready is high,
// so s_tready depends only on the queue fill and never on m_tready. Sustained
// input rate is one byte per cycle as long as the output keeps up; the last payload
// byte and a payload byte that ends a buffer early each make two words.
module host_message_deframer_core (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] data_byte
    input  logic         s_tlast,   // end_of_buffer
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // [1:0] msg_type, [65:2] seq_number,
                                    // [81:66] client_id, [113:82] payload_length,
                                    // [121:114] payload_byte, [122] reject_reason,
                                    // [127:123] zero
    output logic [1:0]   m_tuser,   // [1:0] event_res
    output logic         m_tlast    // payload_last
);

    // Parser state.
    hmd_pkg::phase_t phase_reg, phase_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [63:0] seq_reg, seq_next;
    logic [7:0]  tag_lo_reg, tag_lo_next;
    logic [7:0]  cid_lo_reg, cid_lo_next;
    logic [31:0] len_reg, len_next;
    logic [31:0] rem_reg, rem_next;

    // Result queue.
    hmd_pkg::result_t          q_reg [hmd_pkg::QDepth];
    logic [hmd_pkg::QAw-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [hmd_pkg::QAw-1:0]   wr_ptr_inc;
    logic [hmd_pkg::QAw-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [hmd_pkg::QCw-1:0]   count_reg, count_next;

    logic             s_accept;
    logic             m_pop;
    logic [15:0]      tag_full;
    logic [15:0]      cid_full;
    logic [31:0]      len_full;
    logic             pay_last;
    logic             complete;
    logic [1:0]       n_sw;
    logic [1:0]       n_res;
    logic [1:0]       push_n;
    hmd_pkg::result_t res_a, res_b, res_rej;
    hmd_pkg::result_t head;

    assign s_tready = (count_reg <= hmd_pkg::QCw'(hmd_pkg::QDepth - 2));
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = (count_reg != '0);
    assign m_pop    = m_tvalid && m_tready;

    assign tag_full = {s_tdata, tag_lo_reg};
    assign cid_full = {s_tdata, cid_lo_reg};
    assign len_full = {s_tdata, len_reg[23:0]};
    assign pay_last = (rem_reg <= 32'd1);

    // Byte parser: next state and the words this byte produces.
    always_comb begin
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        seq_next    = seq_reg;
        tag_lo_next = tag_lo_reg;
        cid_lo_next = cid_lo_reg;
        len_next    = len_reg;
        rem_next    = rem_reg;
        res_a       = '0;
        res_b       = '0;
        res_rej     = '0;
        n_sw        = 2'd0;
        n_res       = 2'd0;
        complete    = 1'b0;

        unique case (phase_reg)
            hmd_pkg::PH_SEQ: begin
                seq_next[{cnt_reg, 3'b000} +: 8] = s_tdata;
                if (cnt_reg == 3'd7) begin
                    cnt_next   = 3'd0;
                    phase_next = hmd_pkg::PH_TAG;
                end else begin
                    cnt_next = cnt_reg + 3'd1;
                end
            end
            hmd_pkg::PH_TAG: begin
                if (cnt_reg == 3'd0) begin
                    tag_lo_next = s_tdata;
                    cnt_next    = 3'd1;
                end else begin
                    cnt_next = 3'd0;
                    priority if (tag_full == hmd_pkg::TAG_CONNECT) begin
                        phase_next = hmd_pkg::PH_CLIENT;
                    end else if (tag_full == hmd_pkg::TAG_DISCONNECT) begin
                        res_a.event_res  = hmd_pkg::EV_ACCEPT;
                        res_a.msg_type   = hmd_pkg::MSG_DISCONNECT;
                        res_a.seq_number = seq_reg;
                        n_sw             = 2'd1;
                        complete         = 1'b1;
                        phase_next       = hmd_pkg::PH_IGNORE;
                    end else if (tag_full == hmd_pkg::TAG_STATE) begin
                        phase_next = hmd_pkg::PH_LEN;
                    end else begin
                        res_a.event_res     = hmd_pkg::EV_REJECT;
                        res_a.seq_number    = seq_reg;
                        res_a.reject_reason = hmd_pkg::RSN_UNKNOWN_TAG;
                        n_sw                = 2'd1;
                        complete            = 1'b1;
                        phase_next          = hmd_pkg::PH_IGNORE;
                    end
                end
            end
            hmd_pkg::PH_CLIENT: begin
                if (cnt_reg == 3'd0) begin
                    cid_lo_next = s_tdata;
                    cnt_next    = 3'd1;
                end else begin
                    cnt_next         = 3'd0;
                    res_a.event_res  = hmd_pkg::EV_ACCEPT;
                    res_a.msg_type   = hmd_pkg::MSG_CONNECT;
                    res_a.seq_number = seq_reg;
                    res_a.client_id  = cid_full;
                    n_sw             = 2'd1;
                    complete         = 1'b1;
                    phase_next       = hmd_pkg::PH_IGNORE;
                end
            end
            hmd_pkg::PH_LEN: begin
                len_next[{cnt_reg[1:0], 3'b000} +: 8] = s_tdata;
                if (cnt_reg[1:0] == 2'd3) begin
                    cnt_next = 3'd0;
                    if (len_full == 32'd0) begin
                        res_a.event_res  = hmd_pkg::EV_ACCEPT;
                        res_a.msg_type   = hmd_pkg::MSG_STATE;
                        res_a.seq_number = seq_reg;
                        n_sw             = 2'd1;
                        complete         = 1'b1;
                        phase_next       = hmd_pkg::PH_IGNORE;
                    end else begin
                        rem_next   = len_full;
                        phase_next = hmd_pkg::PH_PAYLOAD;
                    end
                end else begin
                    cnt_next = {1'b0, cnt_reg[1:0]} + 3'd1;
                end
            end
            hmd_pkg::PH_PAYLOAD: begin
                res_a.event_res      = hmd_pkg::EV_BYTE;
                res_a.msg_type       = hmd_pkg::MSG_STATE;
                res_a.seq_number     = seq_reg;
                res_a.payload_length = len_reg;
                res_a.payload_byte   = s_tdata;
                res_a.payload_last   = pay_last;
                n_sw                 = 2'd1;
                if (pay_last) begin
                    rem_next             = 32'd0;
                    res_b.event_res      = hmd_pkg::EV_ACCEPT;
                    res_b.msg_type       = hmd_pkg::MSG_STATE;
                    res_b.seq_number     = seq_reg;
                    res_b.payload_length = len_reg;
                    n_sw                 = 2'd2;
                    complete             = 1'b1;
                    phase_next           = hmd_pkg::PH_IGNORE;
                end else begin
                    rem_next = rem_reg - 32'd1;
                end
            end
            default: begin
                complete = 1'b1;
            end
        endcase

        n_res = n_sw;
        if (s_tlast) begin
            // A truncation report shows the sequence-number bytes taken so far, this byte included.
            res_rej.event_res     = hmd_pkg::EV_REJECT;
            res_rej.seq_number    = seq_next;
            res_rej.reject_reason = hmd_pkg::RSN_TRUNCATED;
            if (!complete) begin
                if (n_sw == 2'd0) begin
                    res_a = res_rej;
                end else begin
                    res_b = res_rej;
                end
                n_res = n_sw + 2'd1;
            end
            phase_next  = hmd_pkg::PH_SEQ;
            cnt_next    = 3'd0;
            seq_next    = '0;
            tag_lo_next = '0;
            cid_lo_next = '0;
            len_next    = '0;
            rem_next    = '0;
        end
    end

    // Queue bookkeeping.
    always_comb begin
        push_n      = s_accept ? n_res : 2'd0;
        wr_ptr_inc  = wr_ptr_reg + hmd_pkg::QAw'(1);
        wr_ptr_next = wr_ptr_reg + hmd_pkg::QAw'(push_n);
        rd_ptr_next = m_pop ? rd_ptr_reg + hmd_pkg::QAw'(1) : rd_ptr_reg;
        count_next  = count_reg + hmd_pkg::QCw'(push_n) - hmd_pkg::QCw'(m_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= hmd_pkg::PH_SEQ;
            cnt_reg    <= '0;
            seq_reg    <= '0;
            tag_lo_reg <= '0;
            cid_lo_reg <= '0;
            len_reg    <= '0;
            rem_reg    <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (s_accept) begin
                phase_reg  <= phase_next;
                cnt_reg    <= cnt_next;
                seq_reg    <= seq_next;
                tag_lo_reg <= tag_lo_next;
                cid_lo_reg <= cid_lo_next;
                len_reg    <= len_next;
                rem_reg    <= rem_next;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Result words carry no reset; of the queue state only the pointers and fill count do.
    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            q_reg[wr_ptr_reg] <= res_a;
        end
        if (push_n == 2'd2) begin
            q_reg[wr_ptr_inc] <= res_b;
        end
    end

    assign head    = q_reg[rd_ptr_reg];
    assign m_tuser = head.event_res;
    assign m_tlast = head.payload_last;
    assign m_tdata = {5'b00000, head.reject_reason, head.payload_byte,
                      head.payload_length, head.client_id, head.seq_number,
                      head.msg_type};

    // The fill count never passes the queue depth.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= hmd_pkg::QCw'(hmd_pkg::QDepth))
        else $error("result queue overfilled");

    // The end of a buffer always brings the parser back to the header start.
    a_eob_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_tlast) |=> (phase_reg == hmd_pkg::PH_SEQ && cnt_reg == 3'd0))
        else $error("parser not restarted after end of buffer");

    // While in the payload at least one byte is still owed.
    a_payload_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == hmd_pkg::PH_PAYLOAD) |-> (rem_reg != 32'd0))
        else $error("payload phase with nothing remaining");

    // Only payload-byte words may carry the last-byte mark.
    a_last_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tuser == hmd_pkg::EV_BYTE))
        else $error("last mark on a verdict word");

    // With no input taken and no output taken the queue fill stays put.
    a_count_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (!s_accept && !m_pop) |=> $stable(count_reg))
        else $error("queue fill moved without a handshake");

endmodule
